// File: sv/gst_pkg.sv
`timescale 1ns / 1ps
// gst_pkg: shared types and constants of the growable slot table
package gst_pkg;

    localparam int REG_W     = 7;
    localparam int FUNC_W    = 2;
    localparam int SLOT_W    = 6;
    localparam int ITEM_W    = 32;
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 1;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_PUSH   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SET    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_CAP   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_SLOTS = 1'b1;

    localparam logic [REG_W-1:0] RST_SLOT_CAP   = 7'd64;
    localparam logic [REG_W-1:0] RST_INIT_SLOTS = 7'd8;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SLOT_W-1:0] index;
        logic [ITEM_W-1:0] item;
    } gst_req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        logic [ITEM_W-1:0] item_out;
        logic [ITEM_W-1:0] released_item;
    } gst_rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_MODIFY,
        S_PUSH,
        S_RESP
    } gst_state_t;

    typedef struct packed {
        logic clear;
        logic rd_en;
        logic wr_en;
        logic occ_we;
        logic occ_val;
    } gst_store_ctl_t;

endpackage

// File: sv/growable_slot_table_top.sv
`timescale 1ns / 1ps
// growable_slot_table_top: slot table with growable active size, scan sequencer and result register
//
// usage
//   request channel (req_valid / req_stall / req): func, index, item; one transfer per operation
//   response channel (rsp_valid / rsp_stall / rsp): one result per request, in request order
//   config port (cfg_we / cfg_index / cfg_data): slot cap and initial size; writing the
//   initial size empties the table; write only while no request is in flight
// sequence (steps from the request transfer to rsp_valid)
//   slots are searched by a single probe/step unit, one slot per cycle, over an occupancy bitmap
//   push: scan up from slot 0 to the lowest free slot, or to the active size when the table grows,
//   then write and result; push into a full table that cannot grow: scan, then result
//   pop: scan down from the top to the highest occupied slot, then memory read, modify, result;
//   no occupied slot: scan of the active range, then result; set_at / remove_at: memory read,
//   modify, result (out of range: result only); one request is in work at a time; req_stall is
//   high from transfer until the result is loaded, so no new request is taken before the last is through
// reset
//   occupancy bitmap cleared at once (all slots free), cap 64, active size min(8, capacity)
// stalls
//   a finished result sits in the output register while the next request is taken; a further
//   result waits in the sequencer until rsp_stall lets the held one go
module growable_slot_table_top
    import gst_pkg::*;
#(
    parameter int MAX_SLOTS = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  gst_req_t             req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output gst_rsp_t             rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data
);

    // active size never passes the 7-bit cap, so storage beyond that is never reached
    localparam int USE_SLOTS  = (MAX_SLOTS < 127) ? MAX_SLOTS : 127;
    localparam int AW         = (USE_SLOTS > 1) ? $clog2(USE_SLOTS) : 1;
    localparam int RST_ACTIVE = (USE_SLOTS < 8) ? USE_SLOTS : 8;
    localparam logic [REG_W-1:0] USE_SLOTS_R  = REG_W'(USE_SLOTS);
    localparam logic [REG_W-1:0] RST_ACTIVE_R = REG_W'(RST_ACTIVE);

    gst_state_t        state_reg, state_next;
    logic [FUNC_W-1:0] func_reg, func_next;
    logic [ITEM_W-1:0] item_reg, item_next;
    logic [REG_W-1:0]  cnt_reg, cnt_next;
    logic [AW-1:0]     target_reg, target_next;
    logic [REG_W-1:0]  active_reg, active_next;
    logic [REG_W-1:0]  cap_reg, cap_next;
    gst_rsp_t          res_reg, res_next;
    gst_rsp_t          rsp_reg, rsp_next;
    logic              rsp_valid_reg, rsp_valid_next;

    gst_store_ctl_t    store_ctl;
    logic [AW-1:0]     store_addr;
    logic              probe_occ;
    logic [ITEM_W-1:0] rd_data;
    logic              rd_occ;

    logic              req_xfer;
    logic              rsp_free;
    logic [REG_W-1:0]  eff_cap;
    logic              can_grow;
    logic [REG_W:0]    grown_wide;
    logic [REG_W-1:0]  grown;
    logic [REG_W-1:0]  index_wide;
    logic [REG_W-1:0]  target_wide;
    logic [REG_W-1:0]  step_base;
    logic [REG_W-1:0]  step_inc;
    logic [REG_W-1:0]  step_sum;
    logic [ITEM_W-1:0] old_item;
    logic [REG_W-1:0]  init_clamped;

    assign req_xfer  = req_valid && !req_stall;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // cap as seen by growth, limited by storage
    assign eff_cap  = (cap_reg > USE_SLOTS_R) ? USE_SLOTS_R : cap_reg;
    assign can_grow = (active_reg < eff_cap);

    // doubling growth, zero grows to one, clamped to the cap
    assign grown_wide = (active_reg == '0) ? (REG_W + 1)'(1) : {active_reg, 1'b0};
    assign grown      = (grown_wide > {1'b0, eff_cap}) ? eff_cap : grown_wide[REG_W-1:0];

    assign init_clamped = (cfg_data < eff_cap) ? cfg_data : eff_cap;

    // shared step unit: slot counter up for push, down for pop (and active - 1 at start)
    assign step_base = (state_reg == S_IDLE) ? active_reg : cnt_reg;
    assign step_inc  = ((state_reg == S_IDLE) || (func_reg == FUNC_POP)) ? '1 : REG_W'(1);
    assign step_sum  = step_base + step_inc;

    assign index_wide  = REG_W'(req.index);
    assign target_wide = REG_W'(target_reg);
    assign old_item    = rd_occ ? rd_data : '0;

    assign store_addr = (state_reg == S_SCAN) ? cnt_reg[AW-1:0] : target_reg;

    gst_slot_store #(
        .DEPTH (USE_SLOTS),
        .AW    (AW)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (store_ctl),
        .addr      (store_addr),
        .wr_data   (item_reg),
        .probe_occ (probe_occ),
        .rd_data   (rd_data),
        .rd_occ    (rd_occ)
    );

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    case (req.func)
                        FUNC_PUSH:
                        begin
                            state_next = S_SCAN;
                        end
                        FUNC_POP:
                        begin
                            state_next = (active_reg == '0) ? S_RESP : S_SCAN;
                        end
                        default:
                        begin
                            state_next = (index_wide >= active_reg) ? S_RESP : S_READ;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (func_reg == FUNC_PUSH)
                begin
                    if (cnt_reg == active_reg)
                    begin
                        state_next = can_grow ? S_PUSH : S_RESP;
                    end
                    else if (!probe_occ)
                    begin
                        state_next = S_PUSH;
                    end
                end
                else
                begin
                    if (probe_occ)
                    begin
                        state_next = S_READ;
                    end
                    else if (cnt_reg == '0)
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_MODIFY;
            end
            S_MODIFY:
            begin
                state_next = S_RESP;
            end
            S_PUSH:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer outputs and datapath
    always_comb
    begin
        func_next      = func_reg;
        item_next      = item_reg;
        cnt_next       = cnt_reg;
        target_next    = target_reg;
        active_next    = active_reg;
        cap_next       = cap_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        store_ctl      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    func_next   = req.func;
                    item_next   = req.item;
                    res_next    = '0;
                    target_next = index_wide[AW-1:0];
                    case (req.func)
                        FUNC_PUSH:
                        begin
                            cnt_next = '0;
                        end
                        FUNC_POP:
                        begin
                            cnt_next = step_sum;
                            if (active_reg == '0)
                            begin
                                res_next.status = STAT_EMPTY;
                            end
                        end
                        default:
                        begin
                            if (index_wide >= active_reg)
                            begin
                                res_next.status = STAT_RANGE;
                            end
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (func_reg == FUNC_PUSH)
                begin
                    if (cnt_reg == active_reg)
                    begin
                        if (can_grow)
                        begin
                            // first new slot; slots past the active range are always free
                            target_next = active_reg[AW-1:0];
                            active_next = grown;
                        end
                        else
                        begin
                            res_next.status = STAT_FULL;
                        end
                    end
                    else if (!probe_occ)
                    begin
                        target_next = cnt_reg[AW-1:0];
                    end
                    else
                    begin
                        cnt_next = step_sum;
                    end
                end
                else
                begin
                    if (probe_occ)
                    begin
                        target_next = cnt_reg[AW-1:0];
                    end
                    else if (cnt_reg == '0)
                    begin
                        res_next.status = STAT_EMPTY;
                    end
                    else
                    begin
                        cnt_next = step_sum;
                    end
                end
            end
            S_READ:
            begin
                store_ctl.rd_en = 1'b1;
            end
            S_MODIFY:
            begin
                store_ctl.occ_we = 1'b1;
                case (func_reg)
                    FUNC_SET:
                    begin
                        res_next.released_item = old_item;
                        store_ctl.wr_en        = 1'b1;
                        store_ctl.occ_val      = (item_reg != '0);
                    end
                    FUNC_POP:
                    begin
                        res_next.item_out = old_item;
                        res_next.slot     = target_wide[SLOT_W-1:0];
                    end
                    default:
                    begin
                        res_next.item_out = old_item;
                    end
                endcase
            end
            S_PUSH:
            begin
                // a zero item leaves the slot free
                store_ctl.wr_en   = 1'b1;
                store_ctl.occ_we  = 1'b1;
                store_ctl.occ_val = (item_reg != '0);
                res_next.slot     = target_wide[SLOT_W-1:0];
            end
            S_RESP:
            begin
                if (rsp_free)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // config writes are to come only while idle; the user is bound, the block does not enforce it
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SLOT_CAP:
                begin
                    cap_next = cfg_data;
                end
                CFG_INIT_SLOTS:
                begin
                    store_ctl.clear = 1'b1;
                    active_next     = init_clamped;
                end
                default:
                begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= RST_ACTIVE_R;
            cap_reg       <= RST_SLOT_CAP;
            rsp_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            cap_reg       <= cap_next;
            rsp_valid_reg <= rsp_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        item_reg   <= item_next;
        target_reg <= target_next;
        res_reg    <= res_next;
        rsp_reg    <= rsp_next;
    end

`ifndef SYNTHESIS
    // active size stays within storage
    a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg <= USE_SLOTS_R)
        else $error("active size beyond storage");

    // a new result appears only out of the response state
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_RESP))
        else $error("response loaded outside response state");

    // one request at a time: a transfer is followed by a stalled request side
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("second request taken while one is in work");
`endif

endmodule

// File: sv/gst_slot_store.sv
`timescale 1ns / 1ps
// gst_slot_store: item memory with an occupancy bitmap (bit set means nonzero entry)
module gst_slot_store
    import gst_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  gst_store_ctl_t      ctl,
    input  logic [AW-1:0]       addr,
    input  logic [ITEM_W-1:0]   wr_data,
    output logic                probe_occ,
    output logic [ITEM_W-1:0]   rd_data,
    output logic                rd_occ
);

    logic [ITEM_W-1:0] mem_reg [DEPTH];
    logic [DEPTH-1:0]  occ_reg;
    logic [ITEM_W-1:0] rd_data_reg;
    logic              rd_occ_reg;

    // memory port, registered read
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem_reg[addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem_reg[addr];
            rd_occ_reg  <= occ_reg[addr];
        end
    end

    // occupancy bits, cleared at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (ctl.clear)
        begin
            occ_reg <= '0;
        end
        else if (ctl.occ_we)
        begin
            occ_reg[addr] <= ctl.occ_val;
        end
    end

    assign probe_occ = occ_reg[addr];
    assign rd_data   = rd_data_reg;
    assign rd_occ    = rd_occ_reg;

endmodule
